// File: design/pwft_pkg.sv
// shared constants for the persistent write flush tracker
package pwft_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ADDRESS_BITS_DEF  = 48;

  // configuration port
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int POOLS_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL0_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL0_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL1_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL1_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POOLS_IN_USE = 3'd4;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // pool counts
  localparam logic [POOLS_W-1:0] POOLS_NONE = 2'd0;
  localparam logic [POOLS_W-1:0] POOLS_TWO  = 2'd2;

endpackage

// File: design/persistent_write_flush_tracker_unit.sv
// top level of the persistent write flush tracker
// steps from input accept to result valid: range check, a sweep of the address memory one entry
//   a cycle with a registered read, then update; a stray write skips the sweep
// one word is in flight at a time, set by the single read port sweep;
//   a new word is taken while the previous result still waits in the output register
// reset clears config, valid bits, entry count and handshake state, not the address memory
module persistent_write_flush_tracker_unit #(
  parameter int TABLE_ENTRIES = pwft_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDRESS_BITS  = pwft_pkg::ADDRESS_BITS_DEF,
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_write,
  input  logic [pwft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwft_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [ADDRESS_BITS-1:0]        address,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           in_pool,
  output logic                           rewrite_unflushed,
  output logic                           flush_hit,
  output logic                           table_full,
  output logic [CNT_W-1:0]               occupancy
);

  localparam int SCAN_W = IDX_W + 1;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  // configuration registers
  logic [pwft_pkg::CFG_W-1:0]   pool0_start;
  logic [pwft_pkg::CFG_W-1:0]   pool0_end;
  logic [pwft_pkg::CFG_W-1:0]   pool1_start;
  logic [pwft_pkg::CFG_W-1:0]   pool1_end;
  logic [pwft_pkg::POOLS_W-1:0] pools_in_use;

  // tracking state: address memory, per-entry valid flops, entry count
  logic [ADDRESS_BITS-1:0]  tracked_address [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [CNT_W-1:0]         entry_count;
  logic [CNT_W-1:0]         entry_count_next;

  // sequencer and captured word
  logic [1:0]              state;
  logic                    act_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic                    inside_q;

  // sweep pipeline
  logic [SCAN_W-1:0]       scan_cnt;
  logic                    rd_en;
  logic                    rd_live;
  logic [IDX_W-1:0]        rd_idx;
  logic [ADDRESS_BITS-1:0] rd_data;
  logic                    found;
  logic [IDX_W-1:0]        hit_idx;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;

  // finish-stage decisions
  logic fin_go;
  logic full_now;
  logic mem_we;
  logic drop_hit;
  logic inside_c;

  // range check on the captured address; bounds resized to the address width
  logic [ADDRESS_BITS-1:0] lo0, hi0, lo1, hi1;
  logic                    act0, act1;

  always_comb begin
    lo0  = ADDRESS_BITS'(pool0_start);
    hi0  = ADDRESS_BITS'(pool0_end);
    lo1  = ADDRESS_BITS'(pool1_start);
    hi1  = ADDRESS_BITS'(pool1_end);
    // a count of three acts like two
    act0 = (pools_in_use != pwft_pkg::POOLS_NONE);
    act1 = (pools_in_use >= pwft_pkg::POOLS_TWO);
    // overlapping ranges collapse into one check; inverted ranges match nothing
    inside_c = (act0 && (lo0 <= addr_q) && (addr_q <= hi0)) ||
               (act1 && (lo1 <= addr_q) && (addr_q <= hi1));
  end

  assign in_ready = (state == S_IDLE);

  // sweep issues one read a cycle until every entry has been read
  assign rd_en = (state == S_SCAN) && (scan_cnt < SCAN_W'(TABLE_ENTRIES));

  // result can leave once the output register is free or being drained
  assign fin_go   = (state == S_FINISH) && (!out_valid || out_ready);
  assign full_now = (entry_count >= CNT_W'(TABLE_ENTRIES));
  // new tracked write goes to the lowest free entry seen in the sweep
  assign mem_we   = fin_go && (act_q == pwft_pkg::ACT_WRITE) && inside_q &&
                    !found && !full_now;
  // flush that found its address frees the entry
  assign drop_hit = fin_go && (act_q == pwft_pkg::ACT_FLUSH) && found;

  always_comb begin
    entry_count_next = entry_count;
    if (mem_we) begin
      entry_count_next = entry_count + CNT_W'(1);
    end else if (drop_hit && (entry_count != '0)) begin
      entry_count_next = entry_count - CNT_W'(1);
    end
  end

  // address memory: one write port, one registered read port; the sweep and the
  // write-back never overlap since one word is in flight at a time
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tracked_address[free_idx] <= addr_q;
    end
    if (rd_en) begin
      rd_data <= tracked_address[scan_cnt[IDX_W-1:0]];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool0_start  <= '0;
      pool0_end    <= '0;
      pool1_start  <= '0;
      pool1_end    <= '0;
      pools_in_use <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pwft_pkg::REG_POOL0_START:  pool0_start  <= cfg_data;
        pwft_pkg::REG_POOL0_END:    pool0_end    <= cfg_data;
        pwft_pkg::REG_POOL1_START:  pool1_start  <= cfg_data;
        pwft_pkg::REG_POOL1_END:    pool1_end    <= cfg_data;
        pwft_pkg::REG_POOLS_IN_USE: pools_in_use <= cfg_data[pwft_pkg::POOLS_W-1:0];
        default: ;
      endcase
    end
  end

  // captured word, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_q  <= action;
      addr_q <= address;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      in_pool           <= inside_q;
      rewrite_unflushed <= inside_q && found;
      flush_hit         <= (act_q == pwft_pkg::ACT_FLUSH) && found;
      table_full        <= inside_q && !found && full_now;
      occupancy         <= entry_count_next;
    end
  end

  // sequencer, sweep pipeline and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      inside_q    <= 1'b0;
      scan_cnt    <= '0;
      rd_live     <= 1'b0;
      rd_idx      <= '0;
      found       <= 1'b0;
      hit_idx     <= '0;
      free_found  <= 1'b0;
      free_idx    <= '0;
      entry_valid <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      // drained result clears valid unless a new result loads in the same cycle
      if (out_valid && out_ready && !fin_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          inside_q   <= (act_q == pwft_pkg::ACT_WRITE) && inside_c;
          scan_cnt   <= '0;
          rd_live    <= 1'b0;
          found      <= 1'b0;
          free_found <= 1'b0;
          // writes outside every range skip the sweep
          if ((act_q == pwft_pkg::ACT_FLUSH) || inside_c) begin
            state <= S_SCAN;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            scan_cnt <= scan_cnt + SCAN_W'(1);
          end
          rd_live <= rd_en;
          rd_idx  <= scan_cnt[IDX_W-1:0];
          // compare stage, in the cycle after the read
          if (rd_live) begin
            if (entry_valid[rd_idx] && (rd_data == addr_q)) begin
              found   <= 1'b1;
              hit_idx <= rd_idx;
            end
            if (!entry_valid[rd_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (rd_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            out_valid   <= 1'b1;
            entry_count <= entry_count_next;
            if (mem_we) begin
              entry_valid[free_idx] <= 1'b1;
            end
            if (drop_hit) begin
              entry_valid[hit_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/pwft_checker.sv
// port-level checker for the persistent write flush tracker, with its bind
module pwft_checker #(
  parameter int TABLE_ENTRIES = pwft_pkg::TABLE_ENTRIES_DEF,
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             in_pool,
  input logic             rewrite_unflushed,
  input logic             flush_hit,
  input logic             table_full,
  input logic [CNT_W-1:0] occupancy
);

  // a flush result that hit carries no write flags
  a_flush_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && flush_hit |-> !in_pool && !rewrite_unflushed && !table_full)
    else $error("flush result with write flags");

  // rewrite and drop only happen to in-range writes, never both
  a_write_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rewrite_unflushed || table_full) |->
      in_pool && !(rewrite_unflushed && table_full))
    else $error("inconsistent write flags");

  // occupancy never exceeds the table
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= CNT_W'(TABLE_ENTRIES))
    else $error("occupancy above table size");

  // a dropped write means the table was full
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> occupancy == CNT_W'(TABLE_ENTRIES))
    else $error("drop reported with free entries");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(occupancy) && $stable(flush_hit))
    else $error("stalled result changed");

endmodule

bind persistent_write_flush_tracker_unit pwft_checker #(
  .TABLE_ENTRIES(TABLE_ENTRIES)
) u_pwft_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .in_pool           (in_pool),
  .rewrite_unflushed (rewrite_unflushed),
  .flush_hit         (flush_hit),
  .table_full        (table_full),
  .occupancy         (occupancy)
);
